[rtl/core/fahq_pkg.sv]
// ============================================================================
// fahq_pkg
// Shared types, sizes and helpers of the four-ary min-heap queue.
// ============================================================================
package fahq_pkg;

  localparam int NODE_W   = 32;
  localparam int KEY_W    = 32;
  localparam int CAPACITY = 1024;
  localparam int ARITY    = 4;
  localparam int LANE_W   = $clog2(ARITY);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int ROW_W    = IDX_W - LANE_W;
  localparam int ROWS     = CAPACITY / ARITY;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [NODE_W-1:0] NODE_NONE = '1;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // One RAM row holds a complete sibling group: row r is the children of entry r.
  typedef entry_t [ARITY-1:0] row_t;

  typedef struct packed {
    logic              found;
    logic [LANE_W-1:0] lane;
  } pick_t;

  // Row and lane of a non-root heap index.
  function automatic logic [ROW_W-1:0] row_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] m;
    m = idx - IDX_W'(1);
    return m[IDX_W-1:LANE_W];
  endfunction

  function automatic logic [LANE_W-1:0] lane_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] m;
    m = idx - IDX_W'(1);
    return m[LANE_W-1:0];
  endfunction

endpackage

[rtl/core/four_ary_min_heap_queue.sv]
// ============================================================================
// four_ary_min_heap_queue
// Four-ary min-heap priority queue of up to 1024 (node, key) entries.
// ============================================================================
//
// Each input word is a push (tuser 0) of a node and its 32-bit unsigned key,
// or a pop (tuser 1) of the entry with the smallest key, and each gives
// exactly one output word: the popped node and key, an empty flag for a pop
// of an empty queue, a drop flag for a push into a full queue, and the number
// of entries held afterwards. The root lives in a register; entries 1 and up
// live in one RAM whose row r holds the four children of entry r, so a sift
// step reads one row. The block works on one word at a time. A word holds it
// from the cycle it is accepted through a final state that loads the output
// register. Each level below the root has a step to issue the RAM read and a
// compare on the registered read data. A push that lands below the root loads
// its row, then takes a step and a compare per parent below the root that it
// is compared with, and a last step at the root register; it starts at most
// five levels down. A pop that leaves entries behind fetches the last entry,
// then takes a step and a compare per entry whose children are compared as
// the refill entry sinks, and a last step when it ends on an entry without
// children; with 1024 entries held it sinks at most five levels below the
// root. Empty pops, pops of the only entry, dropped pushes and pushes into an
// empty queue go straight to the final state. The next word is taken in the
// cycle after the current one has moved into the output register, and that
// move waits while the previous output word is still unclaimed.
//
module four_ary_min_heap_queue (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] node, [63:32] key
  input  logic        in_tuser,   // [0] cmd: 0 push, 1 pop
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [31:0] popped_node, [63:32] popped_key,
                                  // [74:64] occupancy, [79:75] zero
  output logic [1:0]  out_tuser   // [0] was_empty, [1] push_dropped
);

  localparam int OUT_W = 80;
  localparam int OCC_LO = fahq_pkg::NODE_W + fahq_pkg::KEY_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PU_LOAD = 3'd1;
  localparam logic [2:0] ST_PU_STEP = 3'd2;
  localparam logic [2:0] ST_PU_CMP  = 3'd3;
  localparam logic [2:0] ST_PD_LAST = 3'd4;
  localparam logic [2:0] ST_PD_STEP = 3'd5;
  localparam logic [2:0] ST_PD_CMP  = 3'd6;
  localparam logic [2:0] ST_FIN     = 3'd7;

  localparam int FW = fahq_pkg::IDX_W + fahq_pkg::LANE_W;

  // Control state.
  logic [2:0]                  state_r, state_nxt;
  logic [fahq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;

  // Working payload.
  logic [fahq_pkg::IDX_W-1:0]  pos_r, pos_nxt;
  fahq_pkg::row_t              buf_r, buf_nxt;
  fahq_pkg::entry_t            mov_r, mov_nxt;
  fahq_pkg::entry_t            root_r, root_nxt;
  logic [fahq_pkg::NODE_W-1:0] res_node_r, res_node_nxt;
  logic [fahq_pkg::KEY_W-1:0]  res_key_r, res_key_nxt;
  logic                        res_empty_r, res_empty_nxt;
  logic                        res_drop_r, res_drop_nxt;
  logic [OUT_W-1:0]            out_tdata_r, out_tdata_nxt;
  logic [1:0]                  out_tuser_r, out_tuser_nxt;

  // RAM port.
  logic                        wr_en, rd_en;
  logic [fahq_pkg::ROW_W-1:0]  wr_addr, rd_addr;
  fahq_pkg::row_t              wr_row, rd_row;
  fahq_pkg::entry_t            wr_ent;
  logic [$bits(fahq_pkg::row_t)-1:0] rd_bits;

  // Address helpers.
  logic                        in_fire;
  fahq_pkg::entry_t            in_ent;
  logic [fahq_pkg::ROW_W-1:0]  pos_row;
  logic [fahq_pkg::LANE_W-1:0] pos_lane;
  logic [fahq_pkg::IDX_W-1:0]  par_idx;
  fahq_pkg::entry_t            par_ent;
  logic [fahq_pkg::IDX_W-1:0]  cnt_idx;
  logic [FW-1:0]               first_w;
  logic [FW-1:0]               cnt_w;
  logic [fahq_pkg::ARITY-1:0]  lane_vld;
  fahq_pkg::pick_t             pick;
  logic                        out_free;

  assign in_fire = in_tvalid & in_tready;
  assign in_ent  = '{node: in_tdata[31:0], key: in_tdata[63:32]};

  assign pos_row  = fahq_pkg::row_of(pos_r);
  assign pos_lane = fahq_pkg::lane_of(pos_r);
  // The parent of an entry is the number of the row that holds it.
  assign par_idx  = {{fahq_pkg::LANE_W{1'b0}}, pos_row};
  assign rd_row   = fahq_pkg::row_t'(rd_bits);
  assign par_ent  = rd_row[fahq_pkg::lane_of(par_idx)];
  assign cnt_idx  = cnt_r[fahq_pkg::IDX_W-1:0];

  // Index of the first child of pos and which children are still in the heap.
  assign first_w  = {pos_r, {fahq_pkg::LANE_W{1'b0}}} + FW'(1);
  assign cnt_w    = FW'(cnt_r);
  always_comb begin
    for (int j = 0; j < fahq_pkg::ARITY; j++) begin
      lane_vld[j] = (first_w + FW'(j)) < cnt_w;
    end
  end

  fahq_min_sel u_min_sel (
    .row      (rd_row),
    .lane_vld (lane_vld),
    .mov_key  (mov_r.key),
    .pick     (pick)
  );

  // The written row is the held row with the lane of pos replaced.
  always_comb begin
    wr_row           = buf_r;
    wr_row[pos_lane] = wr_ent;
  end
  assign wr_addr = pos_row;

  fahq_ram #(
    .WIDTH ($bits(fahq_pkg::row_t)),
    .DEPTH (fahq_pkg::ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    buf_nxt        = buf_r;
    mov_nxt        = mov_r;
    root_nxt       = root_r;
    res_node_nxt   = res_node_r;
    res_key_nxt    = res_key_r;
    res_empty_nxt  = res_empty_r;
    res_drop_nxt   = res_drop_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    wr_en          = 1'b0;
    wr_ent         = mov_r;
    rd_en          = 1'b0;
    rd_addr        = pos_r[fahq_pkg::ROW_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_node_nxt  = fahq_pkg::NODE_NONE;
          res_key_nxt   = '0;
          res_empty_nxt = 1'b0;
          res_drop_nxt  = 1'b0;
          state_nxt     = ST_FIN;
          if (in_tuser == fahq_pkg::CMD_PUSH) begin
            if (cnt_r == fahq_pkg::CNT_W'(fahq_pkg::CAPACITY)) begin
              res_drop_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_r + fahq_pkg::CNT_W'(1);
              mov_nxt = in_ent;
              pos_nxt = cnt_idx;
              if (cnt_r == '0) begin
                root_nxt = in_ent;
              end else begin
                // Fetch the row the new entry lands in to keep its siblings.
                rd_en     = 1'b1;
                rd_addr   = fahq_pkg::row_of(cnt_idx);
                state_nxt = ST_PU_LOAD;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              res_empty_nxt = 1'b1;
            end else begin
              res_node_nxt = root_r.node;
              res_key_nxt  = root_r.key;
              cnt_nxt      = cnt_r - fahq_pkg::CNT_W'(1);
              if (cnt_r != fahq_pkg::CNT_W'(1)) begin
                // Fetch the last entry, which refills the hole at the root.
                rd_en     = 1'b1;
                rd_addr   = fahq_pkg::row_of(cnt_idx - fahq_pkg::IDX_W'(1));
                state_nxt = ST_PD_LAST;
              end
            end
          end
        end
      end

      ST_PU_LOAD: begin
        buf_nxt   = rd_row;
        state_nxt = ST_PU_STEP;
      end

      ST_PU_STEP: begin
        if (par_idx == '0) begin
          // The parent is the root register.
          wr_en     = 1'b1;
          state_nxt = ST_FIN;
          if (mov_r.key < root_r.key) begin
            wr_ent   = root_r;
            root_nxt = mov_r;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = fahq_pkg::row_of(par_idx);
          state_nxt = ST_PU_CMP;
        end
      end

      ST_PU_CMP: begin
        wr_en = 1'b1;
        if (mov_r.key >= par_ent.key) begin
          state_nxt = ST_FIN;
        end else begin
          // The parent moves down into the hole and the climb goes on.
          wr_ent    = par_ent;
          buf_nxt   = rd_row;
          pos_nxt   = par_idx;
          state_nxt = ST_PU_STEP;
        end
      end

      ST_PD_LAST: begin
        mov_nxt   = rd_row[fahq_pkg::lane_of(cnt_idx)];
        pos_nxt   = '0;
        state_nxt = ST_PD_STEP;
      end

      ST_PD_STEP: begin
        if (first_w >= cnt_w) begin
          // No children left: the sinking entry settles here.
          state_nxt = ST_FIN;
          if (pos_r == '0) begin
            root_nxt = mov_r;
          end else begin
            wr_en = 1'b1;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = pos_r[fahq_pkg::ROW_W-1:0];
          state_nxt = ST_PD_CMP;
        end
      end

      ST_PD_CMP: begin
        if (pick.found) begin
          wr_ent = rd_row[pick.lane];
          if (pos_r == '0) begin
            root_nxt = rd_row[pick.lane];
          end else begin
            wr_en = 1'b1;
          end
          buf_nxt   = rd_row;
          pos_nxt   = first_w[fahq_pkg::IDX_W-1:0] +
                      fahq_pkg::IDX_W'(pick.lane);
          state_nxt = ST_PD_STEP;
        end else begin
          state_nxt = ST_FIN;
          if (pos_r == '0) begin
            root_nxt = mov_r;
          end else begin
            wr_en = 1'b1;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(OUT_W - OCC_LO - fahq_pkg::CNT_W)'(0), cnt_r,
                            res_key_r, res_node_r};
          out_tuser_nxt  = {res_drop_r, res_empty_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    buf_r       <= buf_nxt;
    mov_r       <= mov_nxt;
    root_r      <= root_nxt;
    res_node_r  <= res_node_nxt;
    res_key_r   <= res_key_nxt;
    res_empty_r <= res_empty_nxt;
    res_drop_r  <= res_drop_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The fill count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fahq_pkg::CNT_W'(fahq_pkg::CAPACITY))
    else $error("heap count above capacity");

  // The RAM is only written while a sift is in progress.
  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != ST_IDLE && state_r != ST_FIN))
    else $error("heap RAM written outside a sift");

  // A pop of a non-empty heap drops the count by one on the next edge.
  a_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == fahq_pkg::CMD_POP && cnt_r != '0)
      |=> (cnt_r == $past(cnt_r) - fahq_pkg::CNT_W'(1)))
    else $error("pop did not decrement the count");

  // A finished word moves to the output as soon as the output slot is free.
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_tvalid_r && state_r == ST_IDLE))
    else $error("finished word not presented");

endmodule

[rtl/core/fahq_ram.sv]
// ============================================================================
// fahq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module fahq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/fahq_min_sel.sv]
// ============================================================================
// fahq_min_sel
// Picks the smallest valid child of a sibling row if it is strictly below
// the key of the entry that is sinking; the lowest lane wins on ties.
// ============================================================================
module fahq_min_sel (
  input  fahq_pkg::row_t                  row,
  input  logic [fahq_pkg::ARITY-1:0]      lane_vld,
  input  logic [fahq_pkg::KEY_W-1:0]      mov_key,
  output fahq_pkg::pick_t                 pick
);

  logic                        pair_vld [2];
  logic                        pair_sel [2];
  logic [fahq_pkg::KEY_W-1:0]  pair_key [2];
  logic                        top_sel;
  logic [fahq_pkg::KEY_W-1:0]  top_key;

  // First level of the tree: lanes 0/1 and 2/3, the left one kept on a tie.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      pair_vld[p] = lane_vld[2*p] | lane_vld[2*p+1];
      pair_sel[p] = !(lane_vld[2*p] &&
                      (!lane_vld[2*p+1] || row[2*p].key <= row[2*p+1].key));
      pair_key[p] = pair_sel[p] ? row[2*p+1].key : row[2*p].key;
    end
  end

  assign top_sel = !(pair_vld[0] && (!pair_vld[1] || pair_key[0] <= pair_key[1]));
  assign top_key = top_sel ? pair_key[1] : pair_key[0];

  assign pick.found = (pair_vld[0] | pair_vld[1]) && (top_key < mov_key);
  assign pick.lane  = top_sel ? {1'b1, pair_sel[1]} : {1'b0, pair_sel[0]};

endmodule
